>>> hw/rtl/enumerative_block_codec_defines.svh
// assertion macros shared by the enumerative block codec rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ENUMERATIVE_BLOCK_CODEC_DEFINES_SVH
`define ENUMERATIVE_BLOCK_CODEC_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define EBC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define EBC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ebc_pkg.sv
// shared types, constants and helper functions of the enumerative block codec
// no dependencies; used by every module of the block but ebc_ram
package ebc_pkg;

    // block and word geometry
    localparam int MAX_BLOCK_BITS = 64;
    localparam int WORD_W         = 64;
    localparam int LEN_W          = 7;
    localparam int J_W            = $clog2(MAX_BLOCK_BITS);

    // half pascal table layout: C(m,i) at m*ROW_STRIDE+i for i <= m/2
    localparam int ROW_STRIDE = MAX_BLOCK_BITS / 2;
    localparam int ROW_SHIFT  = $clog2(ROW_STRIDE);
    localparam int ROW_I_W    = ROW_SHIFT + 1;
    localparam int ROM_DEPTH  = MAX_BLOCK_BITS * ROW_STRIDE + ROW_STRIDE + 1;
    localparam int ROM_ADDR_W = $clog2(ROM_DEPTH);

    // stream packing
    localparam int S_TDATA_W = ((2 * LEN_W + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + LEN_W + 7) / 8) * 8;

    // ceil log2 search
    localparam int SRCH_STEPS = $clog2(WORD_W);
    localparam int CNT_W      = $clog2(SRCH_STEPS);
    localparam logic [CNT_W-1:0] SRCH_LAST = CNT_W'(SRCH_STEPS - 1);
    localparam logic [J_W:0]     SRCH_TOP  = (J_W + 1)'(WORD_W / 2);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BITS);

    typedef enum logic [0:0] {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } req_type_t;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LEN_RD,
        ST_LEN_SUB,
        ST_LEN_SRCH,
        ST_STEP_RD,
        ST_STEP_EX,
        ST_DONE
    } main_state_t;

    typedef enum logic [1:0] {
        FL_ROW,
        FL_RD,
        FL_WR,
        FL_DONE
    } fill_state_t;

    // table build port toward the top level
    typedef struct packed {
        logic                  done;
        logic                  wr_en;
        logic [ROM_ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]     wr_data;
        logic [ROM_ADDR_W-1:0] rd_addr;
    } fill_req_t;

    // table address of C(m,i), folded onto the stored half row
    function automatic logic [ROM_ADDR_W-1:0] rom_addr(input logic [LEN_W-1:0] m,
                                                       input logic [LEN_W-1:0] i);
        logic [LEN_W-1:0] ii;
        ii = (i > (m >> 1)) ? LEN_W'(m - i) : i;
        return (ROM_ADDR_W'(m) << ROW_SHIFT) + ROM_ADDR_W'(ii);
    endfunction

    // ones in the low n bits
    function automatic logic [WORD_W-1:0] block_mask(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] msk;
        if (n >= LEN_W'(WORD_W)) begin
            msk = '1;
        end else begin
            msk = (WORD_W'(1) << n) - WORD_W'(1);
        end
        return msk;
    endfunction

endpackage

>>> hw/rtl/ebc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ebc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2081
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/ebc_alu.sv
// shared 64-bit add / subtract unit of the codec sequencer
// depends on ebc_pkg
module ebc_alu (
    input  ebc_pkg::alu_op_t            op,
    input  logic [ebc_pkg::WORD_W-1:0]  a,
    input  logic [ebc_pkg::WORD_W-1:0]  b,
    output logic [ebc_pkg::WORD_W-1:0]  y,
    output logic                        cout
);

    logic                       sub;
    logic [ebc_pkg::WORD_W-1:0] b_in;
    logic [ebc_pkg::WORD_W:0]   sum;

    // one adder; subtract adds the complement plus one, cout high means a >= b
    assign sub  = (op == ebc_pkg::ALU_SUB);
    assign b_in = sub ? ~b : b;
    assign sum  = (ebc_pkg::WORD_W + 1)'(a) + (ebc_pkg::WORD_W + 1)'(b_in)
                + (ebc_pkg::WORD_W + 1)'(sub);
    assign y    = sum[ebc_pkg::WORD_W-1:0];
    assign cout = sum[ebc_pkg::WORD_W];

endmodule

>>> hw/rtl/ebc_table_fill.sv
// builds the half pascal table in the binomial ram after reset, one row at a time
// depends on ebc_pkg; drives the write port and, until done, the read port
module ebc_table_fill (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ebc_pkg::WORD_W-1:0] rd_data,
    output ebc_pkg::fill_req_t         fill_o
);

    ebc_pkg::fill_state_t              fst_reg, fst_next;
    logic [ebc_pkg::LEN_W-1:0]         m_reg, m_next;
    logic [ebc_pkg::ROW_I_W-1:0]       i_reg, i_next;
    logic [ebc_pkg::WORD_W-1:0]        prev_reg, prev_next;
    logic [ebc_pkg::LEN_W-1:0]         i_ext;
    logic                              row_end;

    assign i_ext   = ebc_pkg::LEN_W'(i_reg);
    assign row_end = (i_ext == (m_reg >> 1));

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fst_reg <= ebc_pkg::FL_ROW;
            m_reg   <= '0;
            i_reg   <= '0;
        end else begin
            fst_reg <= fst_next;
            m_reg   <= m_next;
            i_reg   <= i_next;
        end
    end

    // left neighbor from the previous row
    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
    end

    // C(m,i) = C(m-1,i-1) + C(m-1,i), the first term carried from the last step
    always_comb begin
        fst_next        = fst_reg;
        m_next          = m_reg;
        i_next          = i_reg;
        prev_next       = prev_reg;
        fill_o.done     = 1'b0;
        fill_o.wr_en    = 1'b0;
        fill_o.wr_addr  = ebc_pkg::rom_addr(m_reg, i_ext);
        fill_o.wr_data  = prev_reg + rd_data;
        fill_o.rd_addr  = ebc_pkg::rom_addr(ebc_pkg::LEN_W'(m_reg - 1'b1), i_ext);
        unique case (fst_reg)
            ebc_pkg::FL_ROW: begin
                fill_o.wr_en   = 1'b1;
                fill_o.wr_addr = ebc_pkg::rom_addr(m_reg, '0);
                fill_o.wr_data = ebc_pkg::WORD_W'(1);
                prev_next      = ebc_pkg::WORD_W'(1);
                if ((m_reg >> 1) == '0) begin
                    m_next = ebc_pkg::LEN_W'(m_reg + 1'b1);
                end else begin
                    i_next   = ebc_pkg::ROW_I_W'(1);
                    fst_next = ebc_pkg::FL_RD;
                end
            end
            ebc_pkg::FL_RD: begin
                fst_next = ebc_pkg::FL_WR;
            end
            ebc_pkg::FL_WR: begin
                fill_o.wr_en = 1'b1;
                prev_next    = rd_data;
                if (row_end) begin
                    if (m_reg == ebc_pkg::MAX_LEN) begin
                        fst_next = ebc_pkg::FL_DONE;
                    end else begin
                        m_next   = ebc_pkg::LEN_W'(m_reg + 1'b1);
                        fst_next = ebc_pkg::FL_ROW;
                    end
                end else begin
                    i_next   = ebc_pkg::ROW_I_W'(i_reg + 1'b1);
                    fst_next = ebc_pkg::FL_RD;
                end
            end
            ebc_pkg::FL_DONE: begin
                fill_o.done = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/enumerative_block_codec.sv
// Enumerative block codec: encodes an n-bit word with k ones into its offset
// among all such words, or decodes an offset back into the word, and reports
// the offset length ceil(log2 C(n,k)). One request is worked at a time. After
// reset the binomial table is built, with s_tready low. A request with n of 0,
// k of 0 or k >= n skips the length search and the scan. Any other request reads
// C(n,k), searches for the length, then scans bit positions, each scan step
// waiting on the registered read of the binomial ram (a zero bit skips the add
// step when encoding). A new request is taken while the previous result still
// waits in the output register.
// depends on ebc_pkg, ebc_ram, ebc_alu, ebc_table_fill
`include "enumerative_block_codec_defines.svh"

module enumerative_block_codec (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_len[6:0], ones_count[13:7], payload[77:14], zero pad
    input  logic [ebc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [0:0]                    s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[63:0], offset_length[70:64], zero pad
    output logic [ebc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int W = ebc_pkg::WORD_W;
    localparam int L = ebc_pkg::LEN_W;

    // request fields
    logic [L-1:0]              in_n, in_n_sat, in_k;
    logic [W-1:0]              in_payload;
    ebc_pkg::req_type_t        in_type;
    logic                      in_trivial;

    // sequencer state
    ebc_pkg::main_state_t      st_reg, st_next;
    ebc_pkg::req_type_t        op_reg, op_next;
    logic [L-1:0]              n_reg, n_next, k_reg, k_next, rem_reg, rem_next;
    logic [L-1:0]              len_reg, len_next;
    logic [ebc_pkg::J_W-1:0]   j_reg, j_next;
    logic [ebc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]              word_reg, word_next, acc_reg, acc_next;

    // output register
    logic                      m_tvalid_reg;
    logic [W-1:0]              res_out_reg;
    logic [L-1:0]              len_out_reg;
    logic                      out_load;

    // shared units
    ebc_pkg::fill_req_t        fill_req;
    logic [ebc_pkg::ROM_ADDR_W-1:0] main_raddr, ram_raddr;
    logic [W-1:0]              ram_rdata;
    ebc_pkg::alu_op_t          alu_op;
    logic [W-1:0]              alu_a, alu_b, alu_y;
    logic                      alu_cout;

    // length search step
    logic [ebc_pkg::J_W:0]     srch_sh;
    logic [W-1:0]              srch_shifted, srch_x;
    logic [L-1:0]              srch_add;
    logic                      loop_go;

    // unpack the request
    assign in_type    = ebc_pkg::req_type_t'(s_tuser[0]);
    assign in_n       = s_tdata[L-1:0];
    assign in_k       = s_tdata[2*L-1:L];
    assign in_payload = s_tdata[2*L+W-1:2*L];
    assign in_n_sat   = (in_n > ebc_pkg::MAX_LEN) ? ebc_pkg::MAX_LEN : in_n;
    assign in_trivial = (in_n_sat == '0) || (in_k == '0) || (in_k >= in_n_sat);

    assign s_tready = (st_reg == ebc_pkg::ST_IDLE);

    // binomial table build and storage
    ebc_table_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_data (ram_rdata),
        .fill_o  (fill_req)
    );

    assign ram_raddr = fill_req.done ? main_raddr : fill_req.rd_addr;

    ebc_ram #(
        .WIDTH (W),
        .DEPTH (ebc_pkg::ROM_DEPTH)
    ) u_rom (
        .clk   (aclk),
        .we    (fill_req.wr_en),
        .waddr (fill_req.wr_addr),
        .wdata (fill_req.wr_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ebc_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .y    (alu_y),
        .cout (alu_cout)
    );

    // binary search for the top set bit, halving the shift each step
    assign srch_sh      = ebc_pkg::SRCH_TOP >> cnt_reg;
    assign srch_shifted = acc_reg >> srch_sh;
    assign srch_x       = (srch_shifted != '0) ? srch_shifted : acc_reg;
    assign srch_add     = (srch_shifted != '0) ? L'(srch_sh) : '0;

    // scan continues while ones remain and free positions outnumber them
    assign loop_go = (k_reg != '0) && (rem_reg > k_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ebc_pkg::ST_INIT;
        end else begin
            st_reg <= st_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        len_reg  <= len_next;
        j_reg    <= j_next;
        cnt_reg  <= cnt_next;
        word_reg <= word_next;
        acc_reg  <= acc_next;
    end

    // sequencer
    always_comb begin
        st_next    = st_reg;
        op_next    = op_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        acc_next   = acc_reg;
        main_raddr = ebc_pkg::rom_addr(n_reg, k_reg);
        alu_op     = ebc_pkg::ALU_ADD;
        alu_a      = acc_reg;
        alu_b      = ram_rdata;
        unique case (st_reg)
            ebc_pkg::ST_INIT: begin
                if (fill_req.done) begin
                    st_next = ebc_pkg::ST_IDLE;
                end
            end
            ebc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = in_type;
                    n_next    = in_n_sat;
                    k_next    = in_k;
                    rem_next  = in_n_sat;
                    j_next    = '0;
                    word_next = in_payload;
                    len_next  = '0;
                    if (in_trivial) begin
                        // zero ones give 0; all ones give the mask on decode
                        acc_next = ((in_type == ebc_pkg::REQ_DECODE) && (in_k >= in_n_sat))
                                 ? ebc_pkg::block_mask(in_n_sat) : '0;
                        st_next  = ebc_pkg::ST_DONE;
                    end else begin
                        acc_next = '0;
                        st_next  = ebc_pkg::ST_LEN_RD;
                    end
                end
            end
            ebc_pkg::ST_LEN_RD: begin
                // C(n,k) requested here
                st_next = ebc_pkg::ST_LEN_SUB;
            end
            ebc_pkg::ST_LEN_SUB: begin
                alu_op   = ebc_pkg::ALU_SUB;
                alu_a    = ram_rdata;
                alu_b    = W'(1);
                acc_next = alu_cout ? alu_y : '0;
                len_next = '0;
                cnt_next = '0;
                st_next  = ebc_pkg::ST_LEN_SRCH;
            end
            ebc_pkg::ST_LEN_SRCH: begin
                if (cnt_reg == ebc_pkg::SRCH_LAST) begin
                    len_next = L'(len_reg + srch_add + L'(srch_x[0]));
                    acc_next = '0;
                    st_next  = ebc_pkg::ST_STEP_RD;
                end else begin
                    len_next = L'(len_reg + srch_add);
                    acc_next = srch_x;
                    cnt_next = ebc_pkg::CNT_W'(cnt_reg + 1'b1);
                end
            end
            ebc_pkg::ST_STEP_RD: begin
                main_raddr = ebc_pkg::rom_addr(L'(rem_reg - 1'b1), k_reg);
                if (!loop_go) begin
                    // decode: remaining positions must all be ones
                    if ((op_reg == ebc_pkg::REQ_DECODE) && (k_reg != '0)) begin
                        acc_next = acc_reg
                                 | (ebc_pkg::block_mask(n_reg) & ({W{1'b1}} << j_reg));
                    end
                    st_next = ebc_pkg::ST_DONE;
                end else if ((op_reg == ebc_pkg::REQ_ENCODE) && !word_reg[j_reg]) begin
                    // zero bit adds nothing
                    j_next   = ebc_pkg::J_W'(j_reg + 1'b1);
                    rem_next = L'(rem_reg - 1'b1);
                end else begin
                    st_next = ebc_pkg::ST_STEP_EX;
                end
            end
            ebc_pkg::ST_STEP_EX: begin
                if (op_reg == ebc_pkg::REQ_ENCODE) begin
                    alu_op   = ebc_pkg::ALU_ADD;
                    alu_a    = acc_reg;
                    acc_next = alu_y;
                    k_next   = L'(k_reg - 1'b1);
                end else begin
                    alu_op = ebc_pkg::ALU_SUB;
                    alu_a  = word_reg;
                    if (alu_cout) begin
                        word_next = alu_y;
                        acc_next  = acc_reg | (W'(1) << j_reg);
                        k_next    = L'(k_reg - 1'b1);
                    end
                end
                j_next   = ebc_pkg::J_W'(j_reg + 1'b1);
                rem_next = L'(rem_reg - 1'b1);
                st_next  = ebc_pkg::ST_STEP_RD;
            end
            ebc_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    st_next = ebc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // output register, loaded when the previous result is gone or leaving
    assign out_load = (st_reg == ebc_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_out_reg <= acc_reg;
            len_out_reg <= len_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(ebc_pkg::M_TDATA_W - W - L)'(0), len_out_reg, res_out_reg};

    // checks
    `EBC_ASSERT_IMP(a_ready_after_fill, aclk, aresetn, s_tready, fill_req.done,
        "request taken before table build finished")
    `EBC_ASSERT_IMP(a_step_invariant, aclk, aresetn, st_reg == ebc_pkg::ST_STEP_EX,
        (k_reg != '0) && (rem_reg > k_reg), "scan step issued with no free position")
    `EBC_ASSERT_IMP(a_position_sum, aclk, aresetn,
        (st_reg == ebc_pkg::ST_STEP_RD) || (st_reg == ebc_pkg::ST_STEP_EX),
        (L'(j_reg) + rem_reg) == n_reg, "bit index and remaining count disagree")
    `EBC_ASSERT_IMP(a_decode_in_block, aclk, aresetn,
        (st_reg == ebc_pkg::ST_DONE) && (op_reg == ebc_pkg::REQ_DECODE),
        (acc_reg & ~ebc_pkg::block_mask(n_reg)) == '0, "decoded word has bits above the block")
    `EBC_ASSERT_NXT(a_trivial_fast, aclk, aresetn, s_tvalid && s_tready && in_trivial,
        st_reg == ebc_pkg::ST_DONE, "trivial request did not finish at once")

endmodule

>>> dv/enumerative_block_codec_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the enumerative block codec: directed and random requests
// with random stalls on both streams, results checked against an in-bench binomial model
// depends on ebc_pkg and the enumerative_block_codec rtl
module enumerative_block_codec_tb;

    typedef struct {
        ebc_pkg::req_type_t        op;
        logic [ebc_pkg::LEN_W-1:0] n;
        logic [ebc_pkg::LEN_W-1:0] k;
        logic [63:0]               payload;
    } codec_req_t;

    typedef struct {
        logic [63:0]               value;
        logic [ebc_pkg::LEN_W-1:0] len;
    } codec_res_t;

    // scoreboard: binomial table, codec predictor and queue of pending results
    class codec_scoreboard;
        logic [63:0] pascal [0:2080];
        codec_res_t  pending_q[$];
        int          errors;

        function new();
            pascal = '{default: 64'd0};
            pascal[0] = 64'd1;
            for (int m = 1; m <= 64; m++) begin
                pascal[m * 32] = 64'd1;
                for (int i = 1; i <= m / 2; i++) begin
                    pascal[m * 32 + i] = binom(m - 1, i) + binom(m - 1, i - 1);
                end
            end
            errors = 0;
        endfunction

        // C(m,i) folded onto the stored half row
        function logic [63:0] binom(int m, int i);
            int ii;
            ii = i;
            if (m > 64 || i < 0 || i > m) return 64'd0;
            if (ii > m / 2) ii = m - ii;
            return pascal[m * 32 + ii];
        endfunction

        function int bits_for(logic [63:0] v);
            int bits;
            logic [63:0] x;
            bits = 0;
            if (v <= 64'd1) return 0;
            x = v - 64'd1;
            while (x != 64'd0) begin
                bits++;
                x = x >> 1;
            end
            return bits;
        endfunction

        function logic [63:0] low_ones(int n);
            if (n >= 64) return '1;
            return (64'd1 << n) - 64'd1;
        endfunction

        function codec_res_t predict(codec_req_t r);
            codec_res_t  res;
            int          n;
            int          k;
            logic [63:0] off;
            logic [63:0] c;
            n = int'(r.n);
            k = int'(r.k);
            res.value = 64'd0;
            res.len = '0;
            if (n > 64) n = 64;
            if (n == 0) begin
                res.value = 64'd0;
            end else if (k > n) begin
                res.value = (r.op == ebc_pkg::REQ_DECODE) ? low_ones(n) : 64'd0;
            end else begin
                res.len = ebc_pkg::LEN_W'(bits_for(binom(n, k)));
                if (k == 0) begin
                    res.value = 64'd0;
                end else if (k == n) begin
                    res.value = (r.op == ebc_pkg::REQ_DECODE) ? low_ones(n) : 64'd0;
                end else if (r.op == ebc_pkg::REQ_ENCODE) begin
                    // scan upward, stop once the remaining positions must all be ones
                    for (int j = 0; k > 0 && n - j > k; j++) begin
                        if (r.payload[j]) begin
                            res.value += binom(n - j - 1, k);
                            k--;
                        end
                    end
                end else begin
                    off = r.payload;
                    for (int j = 0; k > 0; j++) begin
                        if (n - j <= k) begin
                            res.value |= ~((64'd1 << j) - 64'd1) & low_ones(n);
                            break;
                        end
                        c = binom(n - j - 1, k);
                        if (off >= c) begin
                            res.value |= 64'd1 << j;
                            off -= c;
                            k--;
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_request(codec_req_t r);
            pending_q.push_back(predict(r));
        endfunction

        function void check_result(logic [ebc_pkg::M_TDATA_W-1:0] d);
            codec_res_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result value %h length %0d", $time,
                         d[63:0], d[70:64]);
                return;
            end
            want = pending_q.pop_front();
            if (d[63:0] !== want.value) begin
                errors++;
                $display("%0t: result_value expected %h actual %h", $time,
                         want.value, d[63:0]);
            end
            if (d[70:64] !== want.len) begin
                errors++;
                $display("%0t: offset_length expected %0d actual %0d", $time,
                         want.len, d[70:64]);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ebc_pkg::S_TDATA_W-1:0] s_tdata;
    logic [0:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ebc_pkg::M_TDATA_W-1:0] m_tdata;

    codec_scoreboard sb;
    bit              calm;
    int              ready_hold;

    enumerative_block_codec uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic codec_req_t mk(ebc_pkg::req_type_t op, int n, int k,
                                      logic [63:0] payload);
        codec_req_t r;
        r.op = op;
        r.n = ebc_pkg::LEN_W'(n);
        r.k = ebc_pkg::LEN_W'(k);
        r.payload = payload;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // n-bit word with exactly k ones at random positions
    function automatic logic [63:0] rand_word(int n, int k);
        logic [63:0] w;
        int cnt;
        int pos;
        w = 64'd0;
        cnt = 0;
        while (cnt < k) begin
            pos = $urandom_range(n - 1, 0);
            if (!w[pos]) begin
                w[pos] = 1'b1;
                cnt++;
            end
        end
        return w;
    endfunction

    // drive one request and wait for its handshake
    task automatic send_req(codec_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ebc_pkg::S_TDATA_W'({r.payload, r.k, r.n});
        s_tuser  <= r.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(r);
    endtask

    // hold the request side until all pending results are out
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // result side stalls
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // main sequence
    initial begin
        int                 n;
        int                 k;
        logic [63:0]        c;
        ebc_pkg::req_type_t op;
        codec_req_t         r;
        sb = new();
        calm = 1'b0;
        ready_hold = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes and special cases
        send_req(mk(ebc_pkg::REQ_ENCODE, 64, 32, 64'haaaa_aaaa_aaaa_aaaa));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 32, sb.binom(64, 32) - 64'd1));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 32, '1));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 32, 64'd0));
        send_req(mk(ebc_pkg::REQ_ENCODE, 64, 0, '1));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 0, '1));
        send_req(mk(ebc_pkg::REQ_ENCODE, 64, 64, '1));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 64, 64'd0));
        send_req(mk(ebc_pkg::REQ_ENCODE, 1, 1, 64'd1));
        send_req(mk(ebc_pkg::REQ_DECODE, 1, 1, 64'd0));
        send_req(mk(ebc_pkg::REQ_DECODE, 1, 0, 64'd1));
        // too many ones
        send_req(mk(ebc_pkg::REQ_ENCODE, 5, 9, 64'h1f));
        send_req(mk(ebc_pkg::REQ_DECODE, 5, 9, 64'h3));
        // zero length
        send_req(mk(ebc_pkg::REQ_ENCODE, 0, 0, '1));
        send_req(mk(ebc_pkg::REQ_DECODE, 0, 3, '1));
        // long blocks saturate to 64
        send_req(mk(ebc_pkg::REQ_ENCODE, 127, 64, '1));
        send_req(mk(ebc_pkg::REQ_DECODE, 127, 127, 64'd0));
        send_req(mk(ebc_pkg::REQ_DECODE, 100, 3, 64'd12345));
        send_req(mk(ebc_pkg::REQ_ENCODE, 64, 1, 64'h8000_0000_0000_0000));
        send_req(mk(ebc_pkg::REQ_DECODE, 64, 63, 64'd63));
        // missing ones, extra ones, bits above the block
        send_req(mk(ebc_pkg::REQ_ENCODE, 40, 5, 64'd0));
        send_req(mk(ebc_pkg::REQ_ENCODE, 40, 5, '1));
        send_req(mk(ebc_pkg::REQ_ENCODE, 10, 4, 64'hffff_ffff_ffff_f009));
        send_req(mk(ebc_pkg::REQ_DECODE, 20, 7, '1));
        drain();

        // random: mostly well-formed requests, some noise
        for (int idx = 0; idx < 400; idx++) begin
            calm = ((idx / 50) % 3) == 1;
            op = ebc_pkg::req_type_t'($urandom_range(1));
            if ($urandom_range(99) < 80) begin
                n = ($urandom_range(3) == 0) ? $urandom_range(64, 48) : $urandom_range(40, 1);
                k = $urandom_range(n);
                if (op == ebc_pkg::REQ_ENCODE) begin
                    r = mk(op, n, k, rand_word(n, k));
                end else begin
                    c = sb.binom(n, k);
                    r = mk(op, n, k, ($urandom_range(9) == 0) ? c - 64'd1 : rand64() % c);
                end
            end else begin
                r = mk(op, $urandom_range(127), $urandom_range(127), rand64());
            end
            send_req(r);
            if ($urandom_range(59) == 0) drain();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
